>>> design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on the rising clock, hold off while reset is low.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Check that a condition never shows while enabled.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`endif

>>> design/lct_pkg.sv
// ----------------------------------------------------------------------------
// lct_pkg
// Shared types and constants of the LRU cache traffic counter.
// ----------------------------------------------------------------------------
package lct_pkg;

  localparam int unsigned CNT_W = 32;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // Control part of the link between neighboring cells.
  typedef struct packed {
    logic active;       // search wave is at this link
    logic hit;          // a cell above already matched
    logic hit_dirty;    // dirty mark of the matched entry
    logic carry_valid;  // entry pushed down from above
    logic carry_dirty;
  } lct_ctl_t;

endpackage

>>> design/lct_req_if.sv
// ----------------------------------------------------------------------------
// lct_req_if
// Access request channel: one block access per beat.
// ----------------------------------------------------------------------------
interface lct_req_if #(
  parameter int unsigned ID_BITS = 16
);
  logic               valid;
  logic               ready;
  logic [ID_BITS-1:0] block_id;
  logic               is_write;

  modport source (output valid, output block_id, output is_write, input ready);
  modport sink   (input valid, input block_id, input is_write, output ready);
endinterface

>>> design/lct_rsp_if.sv
// ----------------------------------------------------------------------------
// lct_rsp_if
// Access result channel: hit, eviction and running traffic counts per beat.
// ----------------------------------------------------------------------------
interface lct_rsp_if #(
  parameter int unsigned ID_BITS = 16
);
  logic                      valid;
  logic                      ready;
  logic                      hit;
  logic                      writeback;
  logic                      evicted_valid;
  logic [ID_BITS-1:0]        evicted_id;
  logic [lct_pkg::CNT_W-1:0] read_count;
  logic [lct_pkg::CNT_W-1:0] write_count;

  modport source (output valid, output hit, output writeback, output evicted_valid,
                  output evicted_id, output read_count, output write_count,
                  input ready);
  modport sink   (input valid, input hit, input writeback, input evicted_valid,
                  input evicted_id, input read_count, input write_count,
                  output ready);
endinterface

>>> design/lct_cell.sv
// ----------------------------------------------------------------------------
// lct_cell
// One slot of the recency stack: holds an entry and passes the wave down.
// ----------------------------------------------------------------------------
module lct_cell #(
  parameter int unsigned ID_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  lct_pkg::lct_ctl_t    link_i,
  input  logic [ID_BITS-1:0]   id_i,
  input  logic [ID_BITS-1:0]   carry_tag_i,
  input  logic                 set_dirty_i,
  output lct_pkg::lct_ctl_t    link_o,
  output logic [ID_BITS-1:0]   id_o,
  output logic [ID_BITS-1:0]   carry_tag_o
);
  import lct_pkg::*;

  logic               valid_q, valid_d;
  logic               dirty_q, dirty_d;
  logic [ID_BITS-1:0] tag_q, tag_d;
  lct_ctl_t           ctl_q, ctl_d;
  logic [ID_BITS-1:0] id_q;
  logic [ID_BITS-1:0] ctag_q, ctag_d;
  logic               take;
  logic               match;

  assign take  = link_i.active & ~link_i.hit;
  assign match = take & valid_q & (tag_q == id_i);

  always_comb begin
    valid_d = valid_q;
    dirty_d = dirty_q;
    tag_d   = tag_q;
    ctl_d   = link_i;
    ctag_d  = carry_tag_i;
    if (take) begin
      // take the entry from above in every case
      valid_d = link_i.carry_valid;
      dirty_d = link_i.carry_dirty;
      tag_d   = carry_tag_i;
      if (match) begin
        ctl_d.hit       = 1'b1;
        ctl_d.hit_dirty = dirty_q;
      end else begin
        // push own entry one slot down
        ctl_d.carry_valid = valid_q;
        ctl_d.carry_dirty = dirty_q;
        ctag_d            = tag_q;
      end
    end
    dirty_d = dirty_d | set_dirty_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      dirty_q <= 1'b0;
      ctl_q   <= '0;
    end else begin
      valid_q <= valid_d;
      dirty_q <= dirty_d;
      ctl_q   <= ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tag_q  <= tag_d;
    id_q   <= id_i;
    ctag_q <= ctag_d;
  end

  assign link_o      = ctl_q;
  assign id_o        = id_q;
  assign carry_tag_o = ctag_q;

endmodule

>>> design/lru_cache_traffic_counter.sv
// ----------------------------------------------------------------------------
// lru_cache_traffic_counter
// Fully associative write-back LRU cache model counting block traffic.
// ----------------------------------------------------------------------------
// Usage:
//   req_i carries one access per beat (block_id, is_write). rsp_o returns one
//   result beat per access: hit, writeback, evicted_valid, evicted_id and the
//   saturating miss (read_count) and dirty eviction (write_count) totals.
//   The cache is a chain of WAYS cells ordered by recency, newest at cell 0.
//   An accepted access enters cell 0 as a wave that moves one cell per cycle;
//   each cell it passes takes the entry from above and hands its own down,
//   until the cell holding the block takes it out. The entry that leaves the
//   last cell on a miss is the victim.
//   The accept edge loads cell 0 and the wave then passes down the chain to
//   the bottom cell WAYS - 1; the result then fills the result buffer and
//   after that the output register, where rsp_o.valid rises, and the result
//   beat goes out once rsp_o.ready is high. One access is in flight at a time:
//   a new access is taken only once the last result has left the buffer for
//   the output register, so the access rate falls as the cell chain grows.
//   req_i.ready stays high while a finished result waits in the output
//   register; if the receiver stalls, the next result holds in the buffer and
//   no further access is taken until it moves out.
//   Reset empties all ways and clears both counters at once; no sweep.
// ----------------------------------------------------------------------------
module lru_cache_traffic_counter #(
  parameter int unsigned WAYS    = 256,
  parameter int unsigned ID_BITS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  lct_req_if.sink   req_i,
  lct_rsp_if.source rsp_o
);
  import lct_pkg::*;

  // Links between cells: index 0 feeds the top cell, index WAYS leaves the
  // bottom one.
  lct_ctl_t           link_ctl [WAYS+1];
  logic [ID_BITS-1:0] link_id  [WAYS+1];
  logic [ID_BITS-1:0] link_tag [WAYS+1];

  logic busy_q, busy_d;
  logic accept;
  logic wave_done;
  logic fix_dirty;

  // Result buffer between the chain and the output register.
  logic               pend_valid_q, pend_valid_d;
  logic               pend_hit_q;
  logic               pend_wb_q;
  logic               pend_ev_valid_q;
  logic [ID_BITS-1:0] pend_ev_id_q;

  // Output register and running totals.
  logic               out_valid_q, out_valid_d;
  logic               out_hit_q, out_wb_q, out_ev_valid_q;
  logic [ID_BITS-1:0] out_ev_id_q;
  logic [CNT_W-1:0]   miss_q, miss_d;
  logic [CNT_W-1:0]   wbcnt_q, wbcnt_d;
  logic               load_out;

  assign req_i.ready = ~busy_q;
  assign accept      = req_i.valid & ~busy_q;

  // Launch the wave: the new block goes in at the top as most recent.
  always_comb begin
    link_ctl[0]             = '0;
    link_ctl[0].active      = accept;
    link_ctl[0].carry_valid = 1'b1;
    link_ctl[0].carry_dirty = req_i.is_write;
  end
  assign link_id[0]  = req_i.block_id;
  assign link_tag[0] = req_i.block_id;

  // On a hit the top cell got the write flag only; merge the old dirty mark
  // once the wave has told us what it was.
  assign wave_done = link_ctl[WAYS].active;
  assign fix_dirty = wave_done & link_ctl[WAYS].hit & link_ctl[WAYS].hit_dirty;

  for (genvar g = 0; g < WAYS; g++) begin : g_cell
    lct_cell #(
      .ID_BITS (ID_BITS)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .link_i      (link_ctl[g]),
      .id_i        (link_id[g]),
      .carry_tag_i (link_tag[g]),
      .set_dirty_i ((g == 0) ? fix_dirty : 1'b0),
      .link_o      (link_ctl[g+1]),
      .id_o        (link_id[g+1]),
      .carry_tag_o (link_tag[g+1])
    );
  end

  // Move the buffered result out when the output register is free or taken.
  assign load_out = pend_valid_q & (~out_valid_q | rsp_o.ready);

  always_comb begin
    busy_d = busy_q;
    if (accept) begin
      busy_d = 1'b1;
    end else if (load_out) begin
      busy_d = 1'b0;
    end
  end

  always_comb begin
    pend_valid_d = pend_valid_q;
    if (wave_done) begin
      pend_valid_d = 1'b1;
    end else if (load_out) begin
      pend_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  // Saturating totals, advanced as the result enters the output register.
  always_comb begin
    miss_d  = miss_q;
    wbcnt_d = wbcnt_q;
    if (load_out) begin
      if (!pend_hit_q && (miss_q != CNT_MAX)) begin
        miss_d = miss_q + CNT_W'(1);
      end
      if (pend_wb_q && (wbcnt_q != CNT_MAX)) begin
        wbcnt_d = wbcnt_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q       <= 1'b0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
      miss_q       <= '0;
      wbcnt_q      <= '0;
    end else begin
      busy_q       <= busy_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
      miss_q       <= miss_d;
      wbcnt_q      <= wbcnt_d;
    end
  end

  // Capture what left the bottom cell: on a miss that is the victim.
  always_ff @(posedge clk_i) begin
    if (wave_done) begin
      pend_hit_q      <= link_ctl[WAYS].hit;
      pend_wb_q       <= ~link_ctl[WAYS].hit & link_ctl[WAYS].carry_dirty;
      pend_ev_valid_q <= ~link_ctl[WAYS].hit & link_ctl[WAYS].carry_valid;
      pend_ev_id_q    <= (~link_ctl[WAYS].hit & link_ctl[WAYS].carry_valid) ?
                         link_tag[WAYS] : '0;
    end
    if (load_out) begin
      out_hit_q      <= pend_hit_q;
      out_wb_q       <= pend_wb_q;
      out_ev_valid_q <= pend_ev_valid_q;
      out_ev_id_q    <= pend_ev_id_q;
    end
  end

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.hit           = out_hit_q;
  assign rsp_o.writeback     = out_wb_q;
  assign rsp_o.evicted_valid = out_ev_valid_q;
  assign rsp_o.evicted_id    = out_ev_id_q;
  assign rsp_o.read_count    = miss_q;
  assign rsp_o.write_count   = wbcnt_q;

endmodule

>>> design/lct_checker.sv
// ----------------------------------------------------------------------------
// lct_checker
// Port-level checks of the LRU cache traffic counter, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lct_checker #(
  parameter int unsigned ID_BITS = 16
) (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      rsp_valid_i,
  input logic                      rsp_ready_i,
  input logic                      rsp_hit_i,
  input logic                      rsp_writeback_i,
  input logic                      rsp_evicted_valid_i,
  input logic [ID_BITS-1:0]        rsp_evicted_id_i,
  input logic [lct_pkg::CNT_W-1:0] rsp_read_count_i,
  input logic [lct_pkg::CNT_W-1:0] rsp_write_count_i
);
  import lct_pkg::*;

  // A hit evicts nothing.
  `ASSERT_CLK(a_hit_no_evict, clk_i, rst_ni, rsp_valid_i && rsp_hit_i |-> !rsp_writeback_i && !rsp_evicted_valid_i && (rsp_evicted_id_i == '0), "hit reports an eviction")

  // A dirty eviction needs a valid victim, and an empty victim shows id zero.
  `ASSERT_NEVER(a_wb_needs_victim, clk_i, rst_ni, rsp_valid_i && rsp_writeback_i && !rsp_evicted_valid_i, "writeback without valid victim")
  `ASSERT_CLK(a_empty_victim_id, clk_i, rst_ni, rsp_valid_i && !rsp_evicted_valid_i |-> (rsp_evicted_id_i == '0), "evicted id set without victim")

  // A miss has been counted by the time its beat shows.
  `ASSERT_CLK(a_miss_counted, clk_i, rst_ni, rsp_valid_i && !rsp_hit_i |-> (rsp_read_count_i != '0) && (rsp_read_count_i >= rsp_write_count_i || rsp_read_count_i == CNT_MAX), "miss not counted")

  // A stalled result beat holds.
  `ASSERT_CLK(a_rsp_hold, clk_i, rst_ni, rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_read_count_i) && $stable(rsp_evicted_id_i), "stalled result changed")

endmodule

bind lru_cache_traffic_counter lct_checker #(
  .ID_BITS (ID_BITS)
) u_lct_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .rsp_valid_i         (rsp_o.valid),
  .rsp_ready_i         (rsp_o.ready),
  .rsp_hit_i           (rsp_o.hit),
  .rsp_writeback_i     (rsp_o.writeback),
  .rsp_evicted_valid_i (rsp_o.evicted_valid),
  .rsp_evicted_id_i    (rsp_o.evicted_id),
  .rsp_read_count_i    (rsp_o.read_count),
  .rsp_write_count_i   (rsp_o.write_count)
);
